// ===== sv/cmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunked message framer package
// Shared types, register map and marker text for the framer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmf_pkg;

	// Depth of the queue between the front and the back.
	localparam int CMF_QUEUE_DEPTH = 2;

	// Register map: register index is paddr[3:2].
	localparam int CMF_ADDR_W = 4;
	localparam logic [1:0] REG_SINGLE_MAX = 2'd0;
	localparam logic [1:0] REG_FIRST_MAX  = 2'd1;
	localparam logic [1:0] REG_MIDDLE_MAX = 2'd2;
	localparam logic [1:0] REG_LAST_MAX   = 2'd3;

	// Register reset values.
	localparam logic [7:0] SINGLE_MAX_RST = 8'd54;
	localparam logic [7:0] FIRST_MAX_RST  = 8'd58;
	localparam logic [7:0] MIDDLE_MAX_RST = 8'd62;
	localparam logic [7:0] LAST_MAX_RST   = 8'd58;

	// One input item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] message_length;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// Configuration registers as seen by the front.
	typedef struct packed {
		logic [7:0] single_max;
		logic [7:0] first_max;
		logic [7:0] middle_max;
		logic [7:0] last_max;
	} cfg_t;

	// Marker text that may stand before or after a data byte.
	typedef enum logic [1:0] {
		MK_NONE,
		MK_BEG,
		MK_END,
		MK_TILDE
	} marker_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic [7:0] data_byte;
		marker_t    prefix;
		marker_t    suffix;
	} chunk_desc_t;

	// Number of bytes in a marker.
	function automatic logic [3:0] marker_len(input marker_t mk);
		logic [3:0] len;
		unique case (mk)
			MK_NONE:  len = 4'd0;
			MK_BEG:   len = 4'd5;
			MK_END:   len = 4'd7;
			MK_TILDE: len = 4'd1;
			default:  len = 4'd0;
		endcase
		return len;
	endfunction

	// Byte at a given offset of a marker: "<BEG>", "<END>\r\n" or "~".
	function automatic logic [7:0] marker_byte(input marker_t mk, input logic [3:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (mk)
			MK_BEG: begin
				unique case (idx)
					4'd0:    b = 8'h3C;
					4'd1:    b = 8'h42;
					4'd2:    b = 8'h45;
					4'd3:    b = 8'h47;
					default: b = 8'h3E;
				endcase
			end
			MK_END: begin
				unique case (idx)
					4'd0:    b = 8'h3C;
					4'd1:    b = 8'h45;
					4'd2:    b = 8'h4E;
					4'd3:    b = 8'h44;
					4'd4:    b = 8'h3E;
					4'd5:    b = 8'h0D;
					default: b = 8'h0A;
				endcase
			end
			MK_TILDE: b = 8'h7E;
			default:  b = 8'h00;
		endcase
		return b;
	endfunction

	// Smaller of the remaining count and a limit, a zero limit counting as one.
	function automatic logic [7:0] min_nz(input logic [7:0] rem, input logic [7:0] limit);
		logic [7:0] lim;
		lim = (limit == 8'd0) ? 8'd1 : limit;
		return (rem < lim) ? rem : lim;
	endfunction

endpackage

`default_nettype wire

// ===== sv/cmf_front.sv =====
// ----------------------------------------------------------------------------
// Chunked message framer front
// Accepts input items, tracks message and chunk position, and decides which
// markers go before and after each data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cmf_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  cmf_pkg::in_item_t    item,
	input  cmf_pkg::cfg_t        cfg,
	output cmf_pkg::chunk_desc_t desc
);
	import cmf_pkg::*;

	typedef enum logic [1:0] {
		KIND_FIRST,
		KIND_MIDDLE,
		KIND_FINAL
	} kind_t;

	logic [7:0] pos_q, len_q, left_q;
	logic       single_q;
	kind_t      kind_q;

	logic       first_c;
	logic [7:0] len_c, left_c, rem_c, pos_n, left_n;
	logic       single_c, done_c;
	kind_t      kind_c, kind_n;
	marker_t    prefix_c, suffix_c;

	// Classification of the item against the current state.
	always_comb begin
		first_c  = (pos_q == 8'd0);
		len_c    = first_c ? ((item.message_length == 8'd0) ? 8'd1 : item.message_length)
		                   : len_q;
		single_c = first_c ? (len_c <= cfg.single_max) : single_q;
		kind_c   = first_c ? KIND_FIRST : kind_q;
		left_c   = first_c ? 8'd0 : left_q;
		rem_c    = len_c - pos_q;
		prefix_c = MK_NONE;
		suffix_c = MK_NONE;

		// Opening marker of a packet or a chunk.
		if (first_c && single_c) begin
			prefix_c = MK_BEG;
		end else if (!single_c && left_c == 8'd0) begin
			priority if (kind_c == KIND_FIRST) begin
				prefix_c = MK_BEG;
				left_c   = min_nz(rem_c, cfg.first_max);
			end else if (rem_c <= cfg.last_max) begin
				prefix_c = MK_TILDE;
				kind_c   = KIND_FINAL;
				left_c   = rem_c;
			end else begin
				prefix_c = MK_TILDE;
				kind_c   = KIND_MIDDLE;
				left_c   = min_nz(rem_c, cfg.middle_max);
			end
		end

		pos_n  = pos_q + 8'd1;
		done_c = (pos_n >= len_c);
		left_n = left_c;
		kind_n = kind_c;

		// Closing marker.
		if (single_c) begin
			if (done_c) begin
				suffix_c = MK_END;
			end
		end else begin
			left_n = left_c - 8'd1;
			if (left_n == 8'd0) begin
				if (kind_c == KIND_FINAL) begin
					suffix_c = MK_END;
				end else begin
					suffix_c = MK_TILDE;
					kind_n   = KIND_MIDDLE;
				end
			end
		end

		// End of the message returns to the start of a new one.
		if (done_c) begin
			pos_n  = 8'd0;
			left_n = 8'd0;
			kind_n = KIND_FIRST;
		end

		desc.data_byte = item.data_byte;
		desc.prefix    = prefix_c;
		desc.suffix    = suffix_c;
	end

	// Message and chunk state, advanced on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 8'd0;
			len_q    <= 8'd0;
			left_q   <= 8'd0;
			single_q <= 1'b0;
			kind_q   <= KIND_FIRST;
		end else if (push) begin
			pos_q    <= pos_n;
			len_q    <= len_c;
			left_q   <= left_n;
			single_q <= single_c;
			kind_q   <= kind_n;
		end
	end

endmodule

`default_nettype wire

// ===== sv/cmf_queue.sv =====
// ----------------------------------------------------------------------------
// Chunked message framer queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cmf_queue #(
	parameter int DEPTH = cmf_pkg::CMF_QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  cmf_pkg::chunk_desc_t push_desc,
	output logic                 full,
	input  wire                  pop,
	output logic                 head_valid,
	output cmf_pkg::chunk_desc_t head_desc
);
	import cmf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	chunk_desc_t      entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_desc  = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/cmf_back.sv =====
// ----------------------------------------------------------------------------
// Chunked message framer back
// Expands each classified item into its byte sequence, one byte a cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cmf_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  cmf_pkg::chunk_desc_t head_desc,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output cmf_pkg::out_item_t   out_item
);
	import cmf_pkg::*;

	logic [3:0] idx_q;
	logic [3:0] plen_c, last_c, sidx_c;
	logic [7:0] byte_c;
	logic       is_last_c, load_c;
	out_item_t  out_q;
	logic       out_valid_q;

	// Byte selection within the current item.
	always_comb begin
		plen_c    = marker_len(head_desc.prefix);
		last_c    = plen_c + marker_len(head_desc.suffix);
		sidx_c    = idx_q - plen_c - 4'd1;
		is_last_c = (idx_q == last_c);
		priority if (idx_q < plen_c) begin
			byte_c = marker_byte(head_desc.prefix, idx_q);
		end else if (idx_q == plen_c) begin
			byte_c = head_desc.data_byte;
		end else begin
			byte_c = marker_byte(head_desc.suffix, sidx_c);
		end
	end

	assign load_c    = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load_c && is_last_c;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_c) begin
			out_q.out_byte <= byte_c;
			out_q.run_last <= is_last_c;
		end
	end

	// Byte counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_c) begin
				idx_q       <= is_last_c ? 4'd0 : idx_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/chunked_message_framer_top.sv =====
// ----------------------------------------------------------------------------
// Chunked message framer top level
// Frames message bytes into packets or chunks with text markers.
// ----------------------------------------------------------------------------
// Each input item yields 1 to 13 result items, one per clock cycle while
// out_stall is low: one for a plain data byte, two with a single tilde, up
// to thirteen for a byte that opens and closes a packet. The byte expander
// in the back produces these bytes; the front classifies an item
// combinationally and a small queue lets it accept the next items while
// the back is still emitting. Registers are at byte addresses 0, 4, 8 and
// 12 and should be written only while the block is idle.
`default_nettype none

module chunked_message_framer_top #(
	parameter int QUEUE_DEPTH = cmf_pkg::CMF_QUEUE_DEPTH
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  cmf_pkg::in_item_t                  in_item,
	output logic                               out_valid,
	input  wire                                out_stall,
	output cmf_pkg::out_item_t                 out_item,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [cmf_pkg::CMF_ADDR_W-1:0]     paddr,
	input  wire  [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import cmf_pkg::*;

	cfg_t        cfg_q;
	logic        wr_en;
	logic        push, full, pop, head_valid;
	chunk_desc_t push_desc, head_desc;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite;
	assign in_stall = full;
	assign push     = in_valid && !full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_max <= SINGLE_MAX_RST;
			cfg_q.first_max  <= FIRST_MAX_RST;
			cfg_q.middle_max <= MIDDLE_MAX_RST;
			cfg_q.last_max   <= LAST_MAX_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_SINGLE_MAX: cfg_q.single_max <= pwdata[7:0];
				REG_FIRST_MAX:  cfg_q.first_max  <= pwdata[7:0];
				REG_MIDDLE_MAX: cfg_q.middle_max <= pwdata[7:0];
				REG_LAST_MAX:   cfg_q.last_max   <= pwdata[7:0];
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[3:2])
			REG_SINGLE_MAX: prdata = {24'd0, cfg_q.single_max};
			REG_FIRST_MAX:  prdata = {24'd0, cfg_q.first_max};
			REG_MIDDLE_MAX: prdata = {24'd0, cfg_q.middle_max};
			REG_LAST_MAX:   prdata = {24'd0, cfg_q.last_max};
		endcase
	end

	cmf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (in_item),
		.cfg    (cfg_q),
		.desc   (push_desc)
	);

	cmf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	cmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire

// ===== sim/tb_chunked_message_framer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked message framer testbench
// Drives message bytes through the framer and compares every framed output
// byte against a cycle-free prediction of the marker and chunk layout, while
// both sides idle at random and the register settings change between phases.
// ----------------------------------------------------------------------------

import cmf_pkg::*;

// Kind of chunk the framer is currently filling.
typedef enum logic [1:0] {
	CHUNK_FIRST,
	CHUNK_MIDDLE,
	CHUNK_FINAL
} chunk_kind_e;

// Predicts the framed stream and checks the bytes the framer emits.
class frame_checker;
	localparam logic [7:0] ASCII_CR    = 8'h0D;
	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_TILDE = 8'h7E;

	logic [7:0]  lim_single;
	logic [7:0]  lim_first;
	logic [7:0]  lim_middle;
	logic [7:0]  lim_last;
	logic [7:0]  pos;
	logic [7:0]  len_held;
	logic [7:0]  left_in_chunk;
	bit          one_packet;
	chunk_kind_e kind;
	out_item_t   framed_bytes[$];
	int          errors;

	function new();
		lim_single    = SINGLE_MAX_RST;
		lim_first     = FIRST_MAX_RST;
		lim_middle    = MIDDLE_MAX_RST;
		lim_last      = LAST_MAX_RST;
		pos           = 8'd0;
		len_held      = 8'd0;
		left_in_chunk = 8'd0;
		one_packet    = 1'b0;
		kind          = CHUNK_FIRST;
		errors        = 0;
	endfunction

	function void set_limit(logic [1:0] idx, logic [7:0] value);
		case (idx)
			REG_SINGLE_MAX: lim_single = value;
			REG_FIRST_MAX:  lim_first  = value;
			REG_MIDDLE_MAX: lim_middle = value;
			default:        lim_last   = value;
		endcase
	endfunction

	function int pending();
		return framed_bytes.size();
	endfunction

	function void push_byte(logic [7:0] b);
		out_item_t e;
		e.out_byte = b;
		e.run_last = 1'b0;
		framed_bytes.push_back(e);
	endfunction

	function void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	function void push_end_marker();
		push_text("<END>");
		push_byte(ASCII_CR);
		push_byte(ASCII_LF);
	endfunction

	// Chunk size: the remaining count capped by a limit, where zero means one.
	function logic [7:0] chunk_size(logic [7:0] rem, logic [7:0] limit);
		logic [7:0] cap;
		cap = (limit == 8'd0) ? 8'd1 : limit;
		return (rem < cap) ? rem : cap;
	endfunction

	// Appends the framed bytes that one accepted message byte causes.
	function void take_message_byte(in_item_t it);
		logic [7:0] rem;
		// The first byte latches the length and picks packet or chunked framing.
		if (pos == 8'd0) begin
			len_held      = (it.message_length == 8'd0) ? 8'd1 : it.message_length;
			one_packet    = (len_held <= lim_single);
			kind          = CHUNK_FIRST;
			left_in_chunk = 8'd0;
			if (one_packet)
				push_text("<BEG>");
		end
		// Open a new chunk when the previous one is used up.
		if (!one_packet && left_in_chunk == 8'd0) begin
			rem = len_held - pos;
			if (kind == CHUNK_FIRST) begin
				push_text("<BEG>");
				left_in_chunk = chunk_size(rem, lim_first);
			end else if (rem <= lim_last) begin
				kind = CHUNK_FINAL;
				push_byte(ASCII_TILDE);
				left_in_chunk = rem;
			end else begin
				kind = CHUNK_MIDDLE;
				push_byte(ASCII_TILDE);
				left_in_chunk = chunk_size(rem, lim_middle);
			end
		end
		push_byte(it.data_byte);
		pos = pos + 8'd1;
		// Close the packet or the chunk, and rewind at the end of the message.
		if (one_packet) begin
			if (pos >= len_held) begin
				push_end_marker();
				pos           = 8'd0;
				left_in_chunk = 8'd0;
				kind          = CHUNK_FIRST;
			end
		end else begin
			left_in_chunk = left_in_chunk - 8'd1;
			if (left_in_chunk == 8'd0) begin
				if (kind == CHUNK_FINAL) begin
					push_end_marker();
				end else begin
					push_byte(ASCII_TILDE);
					kind = CHUNK_MIDDLE;
				end
			end
			if (pos >= len_held) begin
				pos           = 8'd0;
				left_in_chunk = 8'd0;
				kind          = CHUNK_FIRST;
			end
		end
		framed_bytes[framed_bytes.size() - 1].run_last = 1'b1;
	endfunction

	// Compares one emitted byte with the oldest predicted one.
	function void check_framed_byte(out_item_t got);
		out_item_t want;
		if (framed_bytes.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR %0t: unexpected output byte %h run_last %b",
					$time, got.out_byte, got.run_last);
		end else begin
			want = framed_bytes.pop_front();
			if (got.out_byte !== want.out_byte || got.run_last !== want.run_last) begin
				errors++;
				if (errors <= 10)
					$display("ERROR %0t: expected byte %h run_last %b, got byte %h run_last %b",
						$time, want.out_byte, want.run_last, got.out_byte, got.run_last);
			end
		end
	endfunction
endclass

module tb_chunked_message_framer_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	in_item_t                  in_item;
	logic                      out_valid;
	logic                      out_stall;
	out_item_t                 out_item;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [CMF_ADDR_W-1:0]     paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;

	frame_checker framing_sb;
	bit           calm_run;
	bit           hold_request;
	int           hold_left;
	int           cycle_count;

	chunked_message_framer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Every accepted output byte is checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			framing_sb.check_framed_byte(out_item);
	end

	// Output side: random stalls, calm stretches and one long hold-off.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (calm_run) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 22);
			end
		end
	end

	function automatic in_item_t mk_item(logic [7:0] data, logic [7:0] msg_len);
		in_item_t it;
		it.data_byte      = data;
		it.message_length = msg_len;
		return it;
	endfunction

	// Offers one item, with random idle cycles first, and waits until taken.
	task automatic send_item(input in_item_t it);
		while (!calm_run && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		framing_sb.take_message_byte(it);
		@(negedge clk);
	endtask

	// Sends n_bytes of a message; a broken one carries stray lengths later on.
	task automatic send_message(input logic [7:0] msg_len, input int n_bytes, input bit broken);
		logic [7:0] len_field;
		for (int i = 0; i < n_bytes; i++) begin
			len_field = (broken && i > 0) ? 8'($urandom_range(0, 255)) : msg_len;
			send_item(mk_item(8'($urandom_range(1, 255)), len_field));
		end
	endtask

	// Completes a message left open by an earlier phase.
	task automatic finish_message();
		if (framing_sb.pos != 8'd0)
			send_message(framing_sb.len_held, int'(framing_sb.len_held - framing_sb.pos), 1'b0);
	endtask

	// Drops valid and waits until every predicted byte has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (framing_sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		framing_sb.set_limit(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [7:0] single, input logic [7:0] first,
			input logic [7:0] middle, input logic [7:0] last);
		wait_drained();
		reg_write(REG_SINGLE_MAX, single);
		reg_write(REG_FIRST_MAX, first);
		reg_write(REG_MIDDLE_MAX, middle);
		reg_write(REG_LAST_MAX, last);
	endtask

	// Limits lean small so that chunking is frequent, with the extremes now and then.
	function automatic logic [7:0] pick_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd255;
		else if (r == 1)
			return 8'd1;
		else if (r < 4)
			return 8'($urandom_range(10, 60));
		return 8'($urandom_range(1, 8));
	endfunction

	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15)
			return 8'($urandom_range(1, 12));
		else if (r < 19)
			return 8'($urandom_range(13, 40));
		return 8'($urandom_range(41, 90));
	endfunction

	// Mostly whole messages with random content, some with stray length fields.
	task automatic random_traffic(input int n_items);
		int         left;
		int         cnt;
		logic [7:0] msg_len;
		bit         broken;
		finish_message();
		left = n_items;
		while (left > 0) begin
			msg_len = pick_length();
			broken  = ($urandom_range(0, 99) < 15);
			cnt     = (int'(msg_len) < left) ? int'(msg_len) : left;
			send_message(msg_len, cnt, broken);
			left -= cnt;
		end
	endtask

	initial begin
		framing_sb   = new();
		calm_run     = 1'b0;
		hold_request = 1'b0;
		cycle_count  = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_item      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset limits: one-byte packets at the data extremes, a zero length
		// and a zero byte, then a message whose later length fields differ.
		send_item(mk_item(8'hFF, 8'd1));
		send_item(mk_item(8'h00, 8'h00));
		send_item(mk_item(8'h01, 8'd3));
		send_item(mk_item(8'h80, 8'd2));
		send_item(mk_item(8'h7F, 8'd0));

		// First, middle and final chunks with tiny limits.
		set_limits(8'd2, 8'd2, 8'd1, 8'd2);
		send_message(8'd7, 7, 1'b0);

		// Zero limits: everything chunked one byte at a time, no final chunk.
		set_limits(8'd0, 8'd0, 8'd0, 8'd0);
		send_message(8'd3, 3, 1'b0);

		// A first chunk that takes the whole message ends on a tilde.
		set_limits(8'd1, 8'd255, 8'd255, 8'd255);
		send_message(8'd4, 4, 1'b0);

		// Limits change halfway through a message.
		set_limits(8'd1, 8'd2, 8'd2, 8'd1);
		send_message(8'd6, 3, 1'b0);
		set_limits(8'd1, 8'd2, 8'd1, 8'd3);
		send_message(8'd6, 3, 1'b0);

		// Random phases: one without idling, one with a long output hold-off.
		for (int p = 0; p < 4; p++) begin
			set_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
			calm_run = (p == 0);
			if (p == 2)
				hold_request = 1'b1;
			random_traffic((p == 0) ? 16 : 8);
		end
		calm_run = 1'b0;
		finish_message();

		// A message just over the packet limit at the reset limits, cut into
		// a first chunk and a final chunk.
		set_limits(SINGLE_MAX_RST, FIRST_MAX_RST, MIDDLE_MAX_RST, LAST_MAX_RST);
		send_message(8'd60, 60, 1'b0);

		wait_drained();
		repeat (20) @(posedge clk);
		if (framing_sb.errors == 0 && framing_sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
